@@ design/scl_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo sidechain link package
// Shared constants, register map and link mode codes.
// ----------------------------------------------------------------------------
package scl_pkg;

	localparam int CV_WIDTH_DEF     = 24;
	localparam int CV_FRAC_BITS_DEF = 16;
	localparam int GAIN_W           = 16;
	localparam int GAIN_FRAC        = 12;
	localparam int GAIN_RESET       = 4096;
	localparam int CEIL_RESET_VOLTS = 10;
	localparam int EPS_DIVISOR      = 100000;
	localparam int ADDR_W           = 5;
	localparam int DATA_W           = 32;

	typedef enum logic [1:0] {
		LINK_INDEP = 2'd0,
		LINK_MAX   = 2'd1,
		LINK_AVG   = 2'd2,
		LINK_MS    = 2'd3
	} link_mode_t;

	typedef enum logic [2:0] {
		REG_LINK_MODE  = 3'd0,
		REG_THR_LEFT   = 3'd1,
		REG_THR_RIGHT  = 3'd2,
		REG_BIAS_LEFT  = 3'd3,
		REG_BIAS_RIGHT = 3'd4,
		REG_GAIN       = 3'd5,
		REG_CEILING    = 3'd6,
		REG_KNEE_WIDTH = 3'd7
	} reg_idx_t;

endpackage

@@ design/stereo_sidechain_cv_link_soft_knee.sv @@
// ----------------------------------------------------------------------------
// Stereo sidechain control voltage link with soft knee
// Each transaction passes through the link stages, the gain product and its
// saturation, and the two bit-serial pipelined divisions of the knee.
// Throughput: one transaction per cycle; a stalled result freezes the whole
// pipeline and stalls the input side in the same cycle.
// Reset clears all valid bits and loads the register defaults; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module stereo_sidechain_cv_link_soft_knee
	import scl_pkg::*;
#(
	parameter int CV_WIDTH     = CV_WIDTH_DEF,
	parameter int CV_FRAC_BITS = CV_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                cv_valid,
	output logic                cv_stall,
	input  logic [CV_WIDTH-1:0] detector_cv_left,
	input  logic [CV_WIDTH-1:0] detector_cv_right,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [CV_WIDTH-1:0] effective_left,
	output logic [CV_WIDTH-1:0] effective_right,
	output logic [CV_WIDTH-1:0] linked_left,
	output logic [CV_WIDTH-1:0] linked_right,
	output logic [CV_WIDTH-1:0] applied_left,
	output logic [CV_WIDTH-1:0] applied_right,
	output logic [CV_WIDTH-1:0] shaped_left,
	output logic [CV_WIDTH-1:0] shaped_right,
	output logic                clamped_left,
	output logic                clamped_right
);

	localparam int W = CV_WIDTH;
	localparam int ProdW = W + GAIN_W;
	localparam int SideDepth = 2*W + 7;
	localparam logic [W-1:0] CeilRst = W'(64'(CEIL_RESET_VOLTS) << CV_FRAC_BITS);

	link_mode_t        link_mode_q;
	logic [W-1:0]      thr_l_q, thr_r_q, bias_l_q, bias_r_q;
	logic [GAIN_W-1:0] gain_q;
	logic [W-1:0]      ceil_q, knee_w_q;

	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	logic [W-1:0]      knee_k, knee_s;

	logic              adv;
	logic              lnk_vld;
	logic [W-1:0]      eff_l, eff_r, lnk_l, lnk_r;
	logic              vld_s4, vld_s5;
	logic [ProdW-1:0]  pl_s4, pr_s4;
	logic [W-1:0]      al_s5, ar_s5;
	logic [W+3:0]      sl_w, sr_w;
	logic [4*W-1:0]    side_in, side_out;
	logic              vld_l, vld_r;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q <= LINK_INDEP;
			thr_l_q     <= '0;
			thr_r_q     <= '0;
			bias_l_q    <= '0;
			bias_r_q    <= '0;
			gain_q      <= GAIN_W'(GAIN_RESET);
			ceil_q      <= CeilRst;
			knee_w_q    <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LINK_MODE:  link_mode_q <= link_mode_t'(pwdata[1:0]);
				REG_THR_LEFT:   thr_l_q     <= pwdata[W-1:0];
				REG_THR_RIGHT:  thr_r_q     <= pwdata[W-1:0];
				REG_BIAS_LEFT:  bias_l_q    <= pwdata[W-1:0];
				REG_BIAS_RIGHT: bias_r_q    <= pwdata[W-1:0];
				REG_GAIN:       gain_q      <= pwdata[GAIN_W-1:0];
				REG_CEILING:    ceil_q      <= pwdata[W-1:0];
				REG_KNEE_WIDTH: knee_w_q    <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_LINK_MODE:  prdata = DATA_W'(link_mode_q);
			REG_THR_LEFT:   prdata = DATA_W'(thr_l_q);
			REG_THR_RIGHT:  prdata = DATA_W'(thr_r_q);
			REG_BIAS_LEFT:  prdata = DATA_W'(bias_l_q);
			REG_BIAS_RIGHT: prdata = DATA_W'(bias_r_q);
			REG_GAIN:       prdata = DATA_W'(gain_q);
			REG_CEILING:    prdata = DATA_W'(ceil_q);
			REG_KNEE_WIDTH: prdata = DATA_W'(knee_w_q);
			default:        prdata = '0;
		endcase
	end

	assign knee_k = (knee_w_q < ceil_q) ? knee_w_q : ceil_q;
	assign knee_s = ceil_q - knee_k;

	assign adv      = !(res_valid && res_stall);
	assign cv_stall = !adv;

	scl_link #(.W(W)) u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (cv_valid),
		.cv_l    (detector_cv_left),
		.cv_r    (detector_cv_right),
		.mode    (link_mode_q),
		.thr_l   (thr_l_q),
		.thr_r   (thr_r_q),
		.bias_l  (bias_l_q),
		.bias_r  (bias_r_q),
		.vld_out (lnk_vld),
		.eff_l   (eff_l),
		.eff_r   (eff_r),
		.lnk_l   (lnk_l),
		.lnk_r   (lnk_r)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s4 <= ProdW'(lnk_l) * ProdW'(gain_q);
			pr_s4 <= ProdW'(lnk_r) * ProdW'(gain_q);
		end
	end

	assign sl_w = pl_s4[ProdW-1:GAIN_FRAC];
	assign sr_w = pr_s4[ProdW-1:GAIN_FRAC];

	always_ff @(posedge clk) begin
		if (adv) begin
			al_s5 <= (|sl_w[W+3:W]) ? '1 : sl_w[W-1:0];
			ar_s5 <= (|sr_w[W+3:W]) ? '1 : sr_w[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= lnk_vld;
			vld_s5 <= vld_s4;
		end
	end

	assign side_in = {eff_l, eff_r, lnk_l, lnk_r};

	scl_delay #(.WIDTH(4*W), .DEPTH(SideDepth)) u_side (
		.clk  (clk),
		.en   (adv),
		.din  (side_in),
		.dout (side_out)
	);

	scl_knee #(.W(W), .F(CV_FRAC_BITS)) u_knee_l (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.vld_in     (vld_s5),
		.x          (al_s5),
		.ceil_cv    (ceil_q),
		.knee_w     (knee_k),
		.knee_start (knee_s),
		.vld_out    (vld_l),
		.applied    (applied_left),
		.shaped     (shaped_left),
		.clamped    (clamped_left)
	);

	scl_knee #(.W(W), .F(CV_FRAC_BITS)) u_knee_r (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.vld_in     (vld_s5),
		.x          (ar_s5),
		.ceil_cv    (ceil_q),
		.knee_w     (knee_k),
		.knee_start (knee_s),
		.vld_out    (vld_r),
		.applied    (applied_right),
		.shaped     (shaped_right),
		.clamped    (clamped_right)
	);

	assign res_valid       = vld_l;
	assign effective_left  = side_out[4*W-1:3*W];
	assign effective_right = side_out[3*W-1:2*W];
	assign linked_left     = side_out[2*W-1:W];
	assign linked_right    = side_out[W-1:0];

	a_lane_valid: assert property (@(posedge clk) disable iff (!arst_n)
		vld_l == vld_r)
		else $error("Left and right knee pipelines lost alignment.");

	a_clamp_left: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && clamped_left |-> applied_left > shaped_left)
		else $error("Left clamp flag raised without a reduction.");

	a_indep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && link_mode_q == LINK_INDEP |->
		linked_left == effective_left && linked_right == effective_right)
		else $error("Independent mode changed a channel in the link stage.");

	a_linked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && link_mode_q != LINK_INDEP |-> linked_left == linked_right)
		else $error("Linked modes gave different channel values.");

endmodule

@@ design/scl_delay.sv @@
// ----------------------------------------------------------------------------
// Sideband delay line
// Shifts a payload word along DEPTH stages in step with the pipeline enable.
// ----------------------------------------------------------------------------
module scl_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

@@ design/scl_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides a 2W-bit dividend by a W-bit divisor, one quotient bit per stage.
// The upper half of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module scl_div #(
	parameter int W = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  logic [2*W-1:0] dividend,
	input  logic [W-1:0]   divisor,
	output logic           vld_out,
	output logic [W-1:0]   quotient
);

	logic         vld_s [W];
	logic [W-1:0] rem_s [W];
	logic [W-1:0] lo_s  [W];
	logic [W-1:0] quo_s [W];
	logic [W-1:0] dvs_s [W];

	for (genvar j = 0; j < W; j++) begin : g_stage
		logic         vld_i;
		logic [W-1:0] rem_i;
		logic [W-1:0] lo_i;
		logic [W-1:0] quo_i;
		logic [W-1:0] dvs_i;
		logic [W:0]   trial;
		logic [W+1:0] diff;

		if (j == 0) begin : g_first
			assign vld_i = vld_in;
			assign rem_i = dividend[2*W-1:W];
			assign lo_i  = dividend[W-1:0];
			assign quo_i = '0;
			assign dvs_i = divisor;
		end else begin : g_next
			assign vld_i = vld_s[j-1];
			assign rem_i = rem_s[j-1];
			assign lo_i  = lo_s[j-1];
			assign quo_i = quo_s[j-1];
			assign dvs_i = dvs_s[j-1];
		end

		assign trial = {rem_i, lo_i[W-1]};
		assign diff  = {1'b0, trial} - {2'b00, dvs_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[j]  <= {lo_i[W-2:0], 1'b0};
				dvs_s[j] <= dvs_i;
				if (!diff[W+1]) begin
					rem_s[j] <= diff[W-1:0];
					quo_s[j] <= {quo_i[W-2:0], 1'b1};
				end else begin
					rem_s[j] <= trial[W-1:0];
					quo_s[j] <= {quo_i[W-2:0], 1'b0};
				end
			end
		end
	end

	assign vld_out  = vld_s[W-1];
	assign quotient = quo_s[W-1];

endmodule

@@ design/scl_link.sv @@
// ----------------------------------------------------------------------------
// Threshold, bias and link logic
// Three stages: floored threshold differences, biased effective values with
// saturation, and the stereo link combination.
// ----------------------------------------------------------------------------
module scl_link
	import scl_pkg::*;
#(
	parameter int W = CV_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  logic [W-1:0] cv_l,
	input  logic [W-1:0] cv_r,
	input  link_mode_t   mode,
	input  logic [W-1:0] thr_l,
	input  logic [W-1:0] thr_r,
	input  logic [W-1:0] bias_l,
	input  logic [W-1:0] bias_r,
	output logic         vld_out,
	output logic [W-1:0] eff_l,
	output logic [W-1:0] eff_r,
	output logic [W-1:0] lnk_l,
	output logic [W-1:0] lnk_r
);

	logic         vld_s1, vld_s2, vld_s3;
	logic [W-1:0] dl_s1, dr_s1;
	logic [W:0]   dms_s1;
	logic [W-1:0] el_s2, er_s2;
	logic [W-1:0] el_s3, er_s3, ll_s3, lr_s3;

	logic [W:0]   sub_l, sub_r;
	logic [W:0]   sum_cv, sum_thr;
	logic [W+1:0] sub_ms;
	logic [W:0]   add_l, add_r;
	logic [W+2:0] add_ms;
	logic [W+1:0] half_ms;
	logic [W-1:0] sat_ms;
	logic [W:0]   pair_sum;

	assign sub_l   = {1'b0, cv_l} - {1'b0, thr_l};
	assign sub_r   = {1'b0, cv_r} - {1'b0, thr_r};
	assign sum_cv  = (W+1)'(cv_l) + (W+1)'(cv_r);
	assign sum_thr = (W+1)'(thr_l) + (W+1)'(thr_r);
	assign sub_ms  = {1'b0, sum_cv} - {1'b0, sum_thr};

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s1  <= sub_l[W] ? '0 : sub_l[W-1:0];
			dr_s1  <= sub_r[W] ? '0 : sub_r[W-1:0];
			dms_s1 <= sub_ms[W+1] ? '0 : sub_ms[W:0];
		end
	end

	assign add_l   = (W+1)'(dl_s1) + (W+1)'(bias_l);
	assign add_r   = (W+1)'(dr_s1) + (W+1)'(bias_r);
	assign add_ms  = (W+3)'(dms_s1) + (W+3)'(bias_l) + (W+3)'(bias_r);
	assign half_ms = add_ms[W+2:1];
	assign sat_ms  = (|half_ms[W+1:W]) ? '1 : half_ms[W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (mode == LINK_MS) begin
				el_s2 <= sat_ms;
				er_s2 <= sat_ms;
			end else begin
				el_s2 <= add_l[W] ? '1 : add_l[W-1:0];
				er_s2 <= add_r[W] ? '1 : add_r[W-1:0];
			end
		end
	end

	assign pair_sum = (W+1)'(el_s2) + (W+1)'(er_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			el_s3 <= el_s2;
			er_s3 <= er_s2;
			case (mode)
				LINK_INDEP: begin
					ll_s3 <= el_s2;
					lr_s3 <= er_s2;
				end
				LINK_MAX: begin
					ll_s3 <= (el_s2 > er_s2) ? el_s2 : er_s2;
					lr_s3 <= (el_s2 > er_s2) ? el_s2 : er_s2;
				end
				LINK_AVG: begin
					ll_s3 <= pair_sum[W:1];
					lr_s3 <= pair_sum[W:1];
				end
				default: begin
					ll_s3 <= el_s2;
					lr_s3 <= el_s2;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign vld_out = vld_s3;
	assign eff_l   = el_s3;
	assign eff_r   = er_s3;
	assign lnk_l   = ll_s3;
	assign lnk_r   = lr_s3;

endmodule

@@ design/scl_knee.sv @@
// ----------------------------------------------------------------------------
// Cubic soft knee limiter
// Classifies the applied value against the knee, evaluates the Hermite
// curve through two pipelined divisions, and raises the clamp flag.
// ----------------------------------------------------------------------------
module scl_knee
	import scl_pkg::*;
#(
	parameter int W = CV_WIDTH_DEF,
	parameter int F = CV_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  logic [W-1:0] x,
	input  logic [W-1:0] ceil_cv,
	input  logic [W-1:0] knee_w,
	input  logic [W-1:0] knee_start,
	output logic         vld_out,
	output logic [W-1:0] applied,
	output logic [W-1:0] shaped,
	output logic         clamped
);

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_PASS,
		SEL_CEIL,
		SEL_CURVE
	} knee_sel_t;

	localparam logic [W-1:0] Eps = W'((64'(1) << F) / EPS_DIVISOR);
	localparam int SideW = 2*W + 2;

	knee_sel_t    sel_c;
	logic         vld_k1, vld_k3, vld_k4, vld_k5;
	logic [W-1:0] x_k1, d_k1, kd_k1;
	knee_sel_t    sel_k1;
	logic         vld_k2;
	logic [2*W-1:0] p1_k2;
	logic [2*W-1:0] p2_k3;
	logic [W-1:0] x_k3, d_k3;
	knee_sel_t    sel_k3;
	logic [W-1:0] x_k4, sh_k4;
	logic [W-1:0] x_k5, sh_k5;
	logic         clamp_k5;

	logic         q1_vld, q2_vld;
	logic [W-1:0] q1, q2;
	logic [SideW-1:0] side1_in, side1_out, side2_in, side2_out;
	logic [W-1:0] x_d1, d_d1, x_d2, d_d2;
	knee_sel_t    sel_d1, sel_d2;
	logic [W+1:0] curve_sum;
	logic [W-1:0] curve_val;
	logic [W-1:0] gap;

	always_comb begin
		if (ceil_cv == '0) begin
			sel_c = SEL_ZERO;
		end else if (knee_w == '0) begin
			sel_c = (x < ceil_cv) ? SEL_PASS : SEL_CEIL;
		end else if (x <= knee_start) begin
			sel_c = SEL_PASS;
		end else if (x >= ceil_cv) begin
			sel_c = SEL_CEIL;
		end else begin
			sel_c = SEL_CURVE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_k1   <= x;
			d_k1   <= x - knee_start;
			kd_k1  <= ceil_cv - x;
			sel_k1 <= sel_c;
			p1_k2  <= (2*W)'(d_k1) * (2*W)'(kd_k1);
		end
	end

	assign side1_in = {x_k1, d_k1, sel_k1};

	scl_delay #(.WIDTH(SideW), .DEPTH(W + 1)) u_side1 (
		.clk  (clk),
		.en   (en),
		.din  (side1_in),
		.dout (side1_out)
	);

	assign x_d1   = side1_out[SideW-1:W+2];
	assign d_d1   = side1_out[W+1:2];
	assign sel_d1 = knee_sel_t'(side1_out[1:0]);

	scl_div #(.W(W)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_k2),
		.dividend (p1_k2),
		.divisor  (knee_w),
		.vld_out  (q1_vld),
		.quotient (q1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			p2_k3  <= (2*W)'(q1) * (2*W)'(d_d1);
			x_k3   <= x_d1;
			d_k3   <= d_d1;
			sel_k3 <= sel_d1;
		end
	end

	assign side2_in = {x_k3, d_k3, sel_k3};

	scl_delay #(.WIDTH(SideW), .DEPTH(W)) u_side2 (
		.clk  (clk),
		.en   (en),
		.din  (side2_in),
		.dout (side2_out)
	);

	assign x_d2   = side2_out[SideW-1:W+2];
	assign d_d2   = side2_out[W+1:2];
	assign sel_d2 = knee_sel_t'(side2_out[1:0]);

	scl_div #(.W(W)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_k3),
		.dividend (p2_k3),
		.divisor  (knee_w),
		.vld_out  (q2_vld),
		.quotient (q2)
	);

	assign curve_sum = (W+2)'(knee_start) + (W+2)'(d_d2) + (W+2)'(q2);
	assign curve_val = (curve_sum > (W+2)'(ceil_cv)) ? ceil_cv : curve_sum[W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			x_k4 <= x_d2;
			case (sel_d2)
				SEL_ZERO:  sh_k4 <= '0;
				SEL_PASS:  sh_k4 <= x_d2;
				SEL_CEIL:  sh_k4 <= ceil_cv;
				SEL_CURVE: sh_k4 <= curve_val;
				default:   sh_k4 <= '0;
			endcase
		end
	end

	assign gap = x_k4 - sh_k4;

	always_ff @(posedge clk) begin
		if (en) begin
			x_k5     <= x_k4;
			sh_k5    <= sh_k4;
			clamp_k5 <= (x_k4 > sh_k4) && (gap > Eps);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_k1 <= 1'b0;
			vld_k2 <= 1'b0;
			vld_k3 <= 1'b0;
			vld_k4 <= 1'b0;
			vld_k5 <= 1'b0;
		end else if (en) begin
			vld_k1 <= vld_in;
			vld_k2 <= vld_k1;
			vld_k3 <= q1_vld;
			vld_k4 <= q2_vld;
			vld_k5 <= vld_k4;
		end
	end

	assign vld_out = vld_k5;
	assign applied = x_k5;
	assign shaped  = sh_k5;
	assign clamped = clamp_k5;

endmodule

@@ verif/tb_stereo_sidechain_cv_link_soft_knee.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo sidechain link testbench
// Drives detector voltage pairs through the link, gain and soft knee block
// under many register settings, and checks every field of every result
// against a local predictor or a directed expectation, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_stereo_sidechain_cv_link_soft_knee;
	import scl_pkg::*;

	localparam int W = CV_WIDTH_DEF;
	localparam logic [63:0] CV_MAX = (64'd1 << W) - 64'd1;
	localparam logic [63:0] CLAMP_EPS = (64'd1 << CV_FRAC_BITS_DEF) / EPS_DIVISOR;
	localparam int DRAIN_WAIT = 2 * W + 20;

	typedef struct packed {
		logic [W-1:0] eff_l;
		logic [W-1:0] eff_r;
		logic [W-1:0] lnk_l;
		logic [W-1:0] lnk_r;
		logic [W-1:0] app_l;
		logic [W-1:0] app_r;
		logic [W-1:0] shp_l;
		logic [W-1:0] shp_r;
		logic         clp_l;
		logic         clp_r;
	} cv_result_t;

	typedef struct packed {
		logic         is_write;
		reg_idx_t     idx;
		logic [31:0]  wval;
		logic [W-1:0] cv_l;
		logic [W-1:0] cv_r;
		logic         typed;
		cv_result_t   want;
	} step_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              cv_valid;
	logic              cv_stall;
	logic [W-1:0]      detector_cv_left, detector_cv_right;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [W-1:0]      effective_left, effective_right;
	logic [W-1:0]      linked_left, linked_right;
	logic [W-1:0]      applied_left, applied_right;
	logic [W-1:0]      shaped_left, shaped_right;
	logic              clamped_left, clamped_right;

	link_mode_t  sh_mode;
	logic [63:0] sh_thr_l, sh_thr_r, sh_bias_l, sh_bias_r, sh_gain, sh_ceiling, sh_knee;

	cv_result_t  pending_results[$];
	step_t       directed_steps[$];
	int          error_count = 0;
	bit          idle_on = 1'b1;
	int unsigned stall_hold = 0;

	stereo_sidechain_cv_link_soft_knee dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cv_valid(cv_valid), .cv_stall(cv_stall),
		.detector_cv_left(detector_cv_left), .detector_cv_right(detector_cv_right),
		.res_valid(res_valid), .res_stall(res_stall),
		.effective_left(effective_left), .effective_right(effective_right),
		.linked_left(linked_left), .linked_right(linked_right),
		.applied_left(applied_left), .applied_right(applied_right),
		.shaped_left(shaped_left), .shaped_right(shaped_right),
		.clamped_left(clamped_left), .clamped_right(clamped_right)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [63:0] clip_cv(input logic [63:0] v);
		return (v > CV_MAX) ? CV_MAX : v;
	endfunction

	function automatic logic [63:0] above_threshold(input logic [63:0] cv, thr, bias);
		logic [63:0] d;
		d = (cv > thr) ? cv - thr : 64'd0;
		return clip_cv(d + bias);
	endfunction

	function automatic logic [63:0] knee_limit(input logic [63:0] x);
		logic [63:0] k, s, d, u, term, r;
		if (sh_ceiling == 0)
			return 64'd0;
		k = (sh_knee < sh_ceiling) ? sh_knee : sh_ceiling;
		if (k == 0)
			return (x < sh_ceiling) ? x : sh_ceiling;
		s = sh_ceiling - k;
		if (x <= s)
			return x;
		if (x >= sh_ceiling)
			return sh_ceiling;
		d = x - s;
		u = (d * (k - d)) / k;
		term = (u * d) / k;
		r = s + d + term;
		return (r > sh_ceiling) ? sh_ceiling : r;
	endfunction

	function automatic cv_result_t predict_link(input logic [W-1:0] l, r);
		cv_result_t  o;
		logic [63:0] sc, st, d, el, er, ll, lr, al, ar, sl, sr;
		if (sh_mode == LINK_MS) begin
			sc = 64'(l) + 64'(r);
			st = sh_thr_l + sh_thr_r;
			d = (sc > st) ? sc - st : 64'd0;
			el = clip_cv((d + sh_bias_l + sh_bias_r) >> 1);
			er = el;
			ll = el;
			lr = el;
		end else begin
			el = above_threshold(64'(l), sh_thr_l, sh_bias_l);
			er = above_threshold(64'(r), sh_thr_r, sh_bias_r);
			case (sh_mode)
				LINK_INDEP: begin
					ll = el;
					lr = er;
				end
				LINK_MAX: begin
					ll = (el > er) ? el : er;
					lr = ll;
				end
				default: begin
					ll = (el + er) >> 1;
					lr = ll;
				end
			endcase
		end
		al = clip_cv((ll * sh_gain) >> GAIN_FRAC);
		ar = clip_cv((lr * sh_gain) >> GAIN_FRAC);
		sl = knee_limit(al);
		sr = knee_limit(ar);
		o.eff_l = el[W-1:0];
		o.eff_r = er[W-1:0];
		o.lnk_l = ll[W-1:0];
		o.lnk_r = lr[W-1:0];
		o.app_l = al[W-1:0];
		o.app_r = ar[W-1:0];
		o.shp_l = sl[W-1:0];
		o.shp_r = sr[W-1:0];
		o.clp_l = (al > sl) && (al - sl > CLAMP_EPS);
		o.clp_r = (ar > sr) && (ar - sr > CLAMP_EPS);
		return o;
	endfunction

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [W-1:0] got, want);
		if (got !== want)
			report($sformatf("%s mismatch: got %h expected %h", name, got, want));
	endtask

	// Result side: pop the oldest expectation for each accepted transaction.
	always @(posedge clk) begin
		cv_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report("result transaction with no expectation");
			end else begin
				want = pending_results.pop_front();
				check_field("effective_left", effective_left, want.eff_l);
				check_field("effective_right", effective_right, want.eff_r);
				check_field("linked_left", linked_left, want.lnk_l);
				check_field("linked_right", linked_right, want.lnk_r);
				check_field("applied_left", applied_left, want.app_l);
				check_field("applied_right", applied_right, want.app_r);
				check_field("shaped_left", shaped_left, want.shp_l);
				check_field("shaped_right", shaped_right, want.shp_r);
				check_field("clamped_left", W'(clamped_left), W'(want.clp_l));
				check_field("clamped_right", W'(clamped_right), W'(want.clp_r));
			end
		end
	end

	// After each accepted result the receiver may hold off at random while idling is on.
	always @(posedge clk or negedge arst_n) begin
		int unsigned n;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold != 0) begin
			res_stall <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else if (res_valid && !res_stall) begin
			n = idle_on ? $urandom_range(0, 3) : 0;
			res_stall <= (n != 0);
			stall_hold <= (n != 0) ? n - 1 : 0;
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic send_cv(input logic [W-1:0] l, r, input logic typed,
			input cv_result_t want);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			cv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cv_valid <= 1'b1;
		detector_cv_left <= l;
		detector_cv_right <= r;
		do @(posedge clk); while (cv_stall);
		pending_results.push_back(typed ? want : predict_link(l, r));
	endtask

	task automatic quiesce();
		cv_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LINK_MODE:  sh_mode = link_mode_t'(val[1:0]);
			REG_THR_LEFT:   sh_thr_l = 64'(val) & CV_MAX;
			REG_THR_RIGHT:  sh_thr_r = 64'(val) & CV_MAX;
			REG_BIAS_LEFT:  sh_bias_l = 64'(val) & CV_MAX;
			REG_BIAS_RIGHT: sh_bias_r = 64'(val) & CV_MAX;
			REG_GAIN:       sh_gain = 64'(val[GAIN_W-1:0]);
			REG_CEILING:    sh_ceiling = 64'(val) & CV_MAX;
			default:        sh_knee = 64'(val) & CV_MAX;
		endcase
	endtask

	task automatic bus_idle();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic step_t reg_step(input reg_idx_t idx, input logic [31:0] val);
		step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.idx = idx;
		s.wval = val;
		return s;
	endfunction

	function automatic step_t cv_step(input logic [W-1:0] l, r);
		step_t s;
		s = '0;
		s.cv_l = l;
		s.cv_r = r;
		return s;
	endfunction

	function automatic step_t known_step(input logic [W-1:0] l, r, input cv_result_t want);
		step_t s;
		s = cv_step(l, r);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	function automatic cv_result_t result_of(input logic [W-1:0] el, er, ll, lr, al, ar,
			sl, sr, input logic cl, cr);
		cv_result_t o;
		o = '{el, er, ll, lr, al, ar, sl, sr, cl, cr};
		return o;
	endfunction

	function automatic logic [63:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return CV_MAX;
			2, 3: return 64'($urandom_range(0, 24'h7FFFF));
			default: return 64'($urandom) & CV_MAX;
		endcase
	endfunction

	// Aims the applied value into the knee region below the ceiling.
	function automatic logic [W-1:0] near_knee(input logic [63:0] thr, bias);
		logic [63:0] span, lin, v;
		span = ((sh_knee < sh_ceiling) ? sh_knee : sh_ceiling) + 64'd1;
		lin = ((sh_ceiling - (64'($urandom) % span)) << GAIN_FRAC)
			/ ((sh_gain == 0) ? 64'd1 : sh_gain);
		v = lin + thr;
		v = (v > bias) ? v - bias : 64'd0;
		v = clip_cv(v);
		return v[W-1:0];
	endfunction

	function automatic logic [W-1:0] pick_cv(input logic [63:0] thr, bias);
		logic [63:0] v;
		case ($urandom_range(0, 6))
			0: v = ($urandom_range(0, 1) != 0) ? CV_MAX : 64'd0;
			1: v = clip_cv(thr + 64'($urandom_range(0, 16'hFFFF)));
			2: v = 64'($urandom_range(0, 24'h3FFFF));
			3, 4: return near_knee(thr, bias);
			default: v = 64'($urandom) & CV_MAX;
		endcase
		return v[W-1:0];
	endfunction

	function automatic logic [31:0] with_junk(input logic [63:0] v, input int width);
		logic [31:0] junk;
		junk = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
		return (junk << width) | v[31:0];
	endfunction

	task automatic random_setup();
		logic [63:0] ceil_v, knee_v, gain_v;
		case ($urandom_range(0, 7))
			0: ceil_v = 64'd0;
			1: ceil_v = CV_MAX;
			default: ceil_v = pick_level();
		endcase
		case ($urandom_range(0, 4))
			0: knee_v = 64'd0;
			1: knee_v = CV_MAX;
			2, 3: knee_v = (ceil_v == 0) ? 64'd0 : 64'($urandom) % ceil_v;
			default: knee_v = pick_level();
		endcase
		case ($urandom_range(0, 4))
			0: gain_v = 64'd0;
			1: gain_v = 64'(GAIN_RESET);
			2: gain_v = 64'hFFFF;
			default: gain_v = 64'($urandom_range(0, 16'hFFFF));
		endcase
		quiesce();
		write_reg(REG_LINK_MODE, with_junk(64'($urandom_range(0, 3)), 2));
		write_reg(REG_THR_LEFT, with_junk(pick_level(), W));
		write_reg(REG_THR_RIGHT, with_junk(pick_level(), W));
		write_reg(REG_BIAS_LEFT, with_junk(pick_level(), W));
		write_reg(REG_BIAS_RIGHT, with_junk(pick_level(), W));
		write_reg(REG_GAIN, with_junk(gain_v, GAIN_W));
		write_reg(REG_CEILING, with_junk(ceil_v, W));
		write_reg(REG_KNEE_WIDTH, with_junk(knee_v, W));
		bus_idle();
	endtask

	initial begin
		int items_sent;
		int phase_len;
		int waited;
		step_t st;

		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cv_valid = 1'b0;
		detector_cv_left = '0;
		detector_cv_right = '0;
		sh_mode = LINK_INDEP;
		sh_thr_l = 0;
		sh_thr_r = 0;
		sh_bias_l = 0;
		sh_bias_r = 0;
		sh_gain = 64'(GAIN_RESET);
		sh_ceiling = 64'(CEIL_RESET_VOLTS) << CV_FRAC_BITS_DEF;
		sh_knee = 0;

		// Reset values: unity gain, ten volt ceiling, hard clamp.
		directed_steps.push_back(known_step(24'h0, 24'h0, '0));
		directed_steps.push_back(known_step(24'hFFFFFF, 24'hFFFFFF,
			result_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
				24'hFFFFFF, 24'h0A0000, 24'h0A0000, 1'b1, 1'b1)));
		directed_steps.push_back(known_step(24'h0A0000, 24'h0,
			result_of(24'h0A0000, 24'h0, 24'h0A0000, 24'h0, 24'h0A0000, 24'h0,
				24'h0A0000, 24'h0, 1'b0, 1'b0)));
		directed_steps.push_back(known_step(24'h0A0001, 24'h1,
			result_of(24'h0A0001, 24'h1, 24'h0A0001, 24'h1, 24'h0A0001, 24'h1,
				24'h0A0000, 24'h1, 1'b1, 1'b0)));
		// Linked maximum, with junk above the mode field.
		directed_steps.push_back(reg_step(REG_LINK_MODE, 32'hFFFF_FFFD));
		directed_steps.push_back(reg_step(REG_THR_LEFT, 32'h0001_0000));
		directed_steps.push_back(reg_step(REG_BIAS_RIGHT, 32'hFF00_8000));
		directed_steps.push_back(cv_step(24'h030000, 24'h018000));
		directed_steps.push_back(cv_step(24'h0, 24'hFFFFFF));
		directed_steps.push_back(reg_step(REG_LINK_MODE, 32'(LINK_AVG)));
		directed_steps.push_back(cv_step(24'hFFFFFF, 24'hFFFFFF));
		directed_steps.push_back(cv_step(24'h012345, 24'h0ABCDE));
		// Mid-side with the channel sum wider than the field.
		directed_steps.push_back(reg_step(REG_LINK_MODE, 32'(LINK_MS)));
		directed_steps.push_back(reg_step(REG_THR_RIGHT, 32'h0002_0000));
		directed_steps.push_back(reg_step(REG_BIAS_LEFT, 32'h00FF_FFFF));
		directed_steps.push_back(cv_step(24'hFFFFFF, 24'hFFFFFF));
		directed_steps.push_back(cv_step(24'h0, 24'h0));
		// Independent channels, full gain, soft knee below the top of range.
		directed_steps.push_back(reg_step(REG_LINK_MODE, 32'(LINK_INDEP)));
		directed_steps.push_back(reg_step(REG_THR_LEFT, 32'h0));
		directed_steps.push_back(reg_step(REG_THR_RIGHT, 32'h0));
		directed_steps.push_back(reg_step(REG_BIAS_LEFT, 32'h0));
		directed_steps.push_back(reg_step(REG_BIAS_RIGHT, 32'h0));
		directed_steps.push_back(reg_step(REG_GAIN, 32'hFFFF_FFFF));
		directed_steps.push_back(reg_step(REG_CEILING, 32'h00FF_FFFF));
		directed_steps.push_back(reg_step(REG_KNEE_WIDTH, 32'h0010_0000));
		directed_steps.push_back(cv_step(24'h004000, 24'h000100));
		directed_steps.push_back(cv_step(24'hFFFFFF, 24'h0FFFFF));
		directed_steps.push_back(cv_step(24'h0F0800, 24'h0FF000));
		// Zero gain gives zero applied voltage.
		directed_steps.push_back(reg_step(REG_GAIN, 32'h0));
		directed_steps.push_back(known_step(24'hFFFFFF, 24'hFFFFFF,
			result_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0,
				24'h0, 24'h0, 1'b0, 1'b0)));
		// A zero ceiling forces the shaped voltage to zero.
		directed_steps.push_back(reg_step(REG_GAIN, 32'(GAIN_RESET)));
		directed_steps.push_back(reg_step(REG_CEILING, 32'h0));
		directed_steps.push_back(known_step(24'h050000, 24'h0,
			result_of(24'h050000, 24'h0, 24'h050000, 24'h0, 24'h050000, 24'h0,
				24'h0, 24'h0, 1'b1, 1'b0)));
		// Knee wider than the ceiling, then the narrowest knee.
		directed_steps.push_back(reg_step(REG_CEILING, 32'h0010_0000));
		directed_steps.push_back(reg_step(REG_KNEE_WIDTH, 32'hFFFF_FFFF));
		directed_steps.push_back(cv_step(24'h080000, 24'h100000));
		directed_steps.push_back(cv_step(24'h000001, 24'h0FFFFF));
		directed_steps.push_back(reg_step(REG_KNEE_WIDTH, 32'h1));
		directed_steps.push_back(cv_step(24'h0FFFFF, 24'h100000));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			st = directed_steps[i];
			if (st.is_write) begin
				quiesce();
				write_reg(st.idx, st.wval);
				bus_idle();
			end else begin
				send_cv(st.cv_l, st.cv_r, st.typed, st.want);
			end
		end

		items_sent = 0;
		while (items_sent < 1700) begin
			random_setup();
			idle_on = ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(20, 120);
			repeat (phase_len) begin
				send_cv(pick_cv(sh_thr_l, sh_bias_l), pick_cv(sh_thr_r, sh_bias_r),
					1'b0, '0);
				items_sent++;
			end
		end

		cv_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0)
			report($sformatf("%0d expected results never arrived",
				pending_results.size()));
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/scl_pkg.sv
design/scl_delay.sv
design/scl_div.sv
design/scl_link.sv
design/scl_knee.sv
design/stereo_sidechain_cv_link_soft_knee.sv
verif/tb_stereo_sidechain_cv_link_soft_knee.sv
